/* hw/rtl/i2cm_pkg.sv */
// Shared types and constants of the I2C master byte transfer unit.
package i2cm_pkg;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WR1   = 2'd1;
	localparam logic [1:0] CMD_WR2   = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_ADDR  = 2'd1;
	localparam logic [1:0] ERR_DATA  = 2'd2;

	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	localparam logic [15:0] PHASE_TICKS_RESET = 16'd16;
	localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd3;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

	localparam int QUEUE_DEPTH = 2;

	// One classified tick as it waits in the queue.
	typedef struct packed {
		logic       start;
		logic [1:0] command;
		logic [7:0] addr_byte;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       clock_level;
		logic       data_level;
	} item_t;

	typedef struct packed {
		logic [15:0] phase_ticks;
		logic [2:0]  retry_limit;
	} cfg_t;

endpackage

/* hw/rtl/i2c_master_byte_transfer_unit.sv */
// Top level of the tick-driven I2C master: configuration registers, front queue and bus engine.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    command, device_address, first_byte,
//                                             second_byte, clock_level, data_level
//  out      output     out_valid / out_ready  clock_release, data_release, busy_res,
//                                             done_res, acknowledged, error_code, read_byte
//  cfg      input      cfg_write_enable       cfg_index, cfg_data
//
// Every item is one bus tick and yields one result item, one item per clock cycle while the output is not stalled.
// A result passes through the two-entry queue and then the phase sequencer, which registers
// the result.
// Reset restores phase_ticks 16 and retry_limit 3 and returns the sequencer to idle.
// A stalled output holds the sequencer; the queue then takes up to two more items before
// in_ready falls.
module i2c_master_byte_transfer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  device_address,
	input  logic [7:0]  first_byte,
	input  logic [7:0]  second_byte,
	input  logic        clock_level,
	input  logic        data_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        clock_release,
	output logic        data_release,
	output logic        busy_res,
	output logic        done_res,
	output logic        acknowledged,
	output logic [1:0]  error_code,
	output logic [7:0]  read_byte
);
	import i2cm_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks <= PHASE_TICKS_RESET;
			cfg_q.retry_limit <= RETRY_LIMIT_RESET;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				CFG_PHASE_TICKS: cfg_q.phase_ticks <= cfg_data;
				CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	i2cm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.device_address (device_address),
		.first_byte     (first_byte),
		.second_byte    (second_byte),
		.clock_level    (clock_level),
		.data_level     (data_level),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	i2cm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.clock_release (clock_release),
		.data_release  (data_release),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.acknowledged  (acknowledged),
		.error_code    (error_code),
		.read_byte     (read_byte)
	);

	// The stop condition completes only as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code != 2'd3)
		else $error("undefined error code");

	// An idle bus has both lines released.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> clock_release && data_release)
		else $error("bus line driven while idle");

	// A queued item moves on whenever the output is free.
	a_queue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !out_valid |=> out_valid)
		else $error("queued item not processed");

endmodule

/* hw/rtl/i2cm_front.sv */
// Front end: accepts ticks, classifies the command and queues them for the bus engine.
module i2cm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [7:0]          device_address,
	input  logic [7:0]          first_byte,
	input  logic [7:0]          second_byte,
	input  logic                clock_level,
	input  logic                data_level,
	output logic                q_valid,
	output i2cm_pkg::item_t     q_item,
	input  logic                q_pop
);
	import i2cm_pkg::*;

	item_t      entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      new_item;
	logic       push;
	logic       pop;

	always_comb begin
		new_item.start       = (command != CMD_NONE);
		new_item.command     = command;
		// A read sends the address plus one, which sets the direction bit only when bit 0 is clear.
		new_item.addr_byte   = (command == CMD_READ) ? device_address + 8'd1 : device_address;
		new_item.first_byte  = first_byte;
		new_item.second_byte = second_byte;
		new_item.clock_level = clock_level;
		new_item.data_level  = data_level;
	end

	assign in_ready = (count_q != 2'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hw/rtl/i2cm_back.sv */
// Back end: the bus phase sequencer, advanced by one queued tick at a time, with the result register.
module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  i2cm_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  i2cm_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            clock_release,
	output logic            data_release,
	output logic            busy_res,
	output logic            done_res,
	output logic            acknowledged,
	output logic [1:0]      error_code,
	output logic [7:0]      read_byte
);
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_TX_LOW, ST_TX_HIGH, ST_ACK_LOW, ST_ACK_HIGH,
		ST_RX_LOW, ST_RX_HIGH, ST_NACK_LOW, ST_NACK_HIGH, ST_STOP_LOW,
		ST_STOP_HIGH, ST_STOP_END
	} state_t;

	state_t      state_q, state_n;
	logic [15:0] phase_cnt_q, phase_cnt_n;
	logic [3:0]  bit_cnt_q, bit_cnt_n;
	logic [7:0]  shift_q, shift_n;
	logic [2:0]  retry_q, retry_n;
	logic [1:0]  byte_idx_q, byte_idx_n;
	logic [7:0]  held_q [3];
	logic        held_load;
	logic [1:0]  held_cmd_q, held_cmd_n;
	logic [1:0]  status_q, status_n;
	logic        ack_q, ack_n;
	logic [7:0]  read_q, read_n;
	logic        done_n;
	logic        scl_n, sda_n;
	logic        step;
	logic [15:0] ticks;
	logic [2:0]  limit;
	logic        needs_clock;
	logic        ack_bit;

	assign step  = q_valid && (!out_valid || out_ready);
	assign q_pop = step;
	assign ticks = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
	assign limit = (cfg.retry_limit == 3'd0) ? 3'd1 : cfg.retry_limit;
	assign needs_clock = (state_q == ST_TX_HIGH) || (state_q == ST_ACK_HIGH) ||
		(state_q == ST_RX_HIGH) || (state_q == ST_NACK_HIGH) || (state_q == ST_STOP_HIGH);
	assign ack_bit = ~q_item.data_level;

	always_comb begin
		state_n     = state_q;
		phase_cnt_n = phase_cnt_q;
		bit_cnt_n   = bit_cnt_q;
		shift_n     = shift_q;
		retry_n     = retry_q;
		byte_idx_n  = byte_idx_q;
		held_cmd_n  = held_cmd_q;
		status_n    = status_q;
		ack_n       = ack_q;
		read_n      = read_q;
		done_n      = 1'b0;
		held_load   = 1'b0;

		if (state_q == ST_IDLE) begin
			if (q_item.start) begin
				held_load   = 1'b1;
				held_cmd_n  = q_item.command;
				status_n    = ERR_ADDR;
				ack_n       = 1'b0;
				read_n      = 8'd0;
				retry_n     = 3'd0;
				byte_idx_n  = 2'd0;
				bit_cnt_n   = 4'd0;
				state_n     = ST_START;
				phase_cnt_n = 16'd0;
			end
		end else if ({1'b0, phase_cnt_q} + 17'd1 < {1'b0, ticks}) begin
			phase_cnt_n = phase_cnt_q + 16'd1;
		end else if (needs_clock && !q_item.clock_level) begin
			// The slave is stretching the clock, so this phase is held.
		end else begin
			phase_cnt_n = 16'd0;
			case (state_q)
				ST_START: begin
					shift_n   = held_q[0];
					bit_cnt_n = 4'd0;
					state_n   = ST_TX_LOW;
				end
				ST_TX_LOW: state_n = ST_TX_HIGH;
				ST_TX_HIGH: begin
					shift_n   = {shift_q[6:0], 1'b0};
					bit_cnt_n = bit_cnt_q + 4'd1;
					state_n   = (bit_cnt_q + 4'd1 >= BITS_PER_BYTE) ? ST_ACK_LOW : ST_TX_LOW;
				end
				ST_ACK_LOW: state_n = ST_ACK_HIGH;
				ST_ACK_HIGH: begin
					ack_n = ack_bit;
					if (byte_idx_q == 2'd0) begin
						if (ack_bit) begin
							if (held_cmd_q == CMD_READ) begin
								status_n  = ERR_NONE;
								shift_n   = 8'd0;
								bit_cnt_n = 4'd0;
								state_n   = ST_RX_LOW;
							end else begin
								status_n   = ERR_DATA;
								byte_idx_n = 2'd1;
								shift_n    = held_q[1];
								bit_cnt_n  = 4'd0;
								state_n    = ST_TX_LOW;
							end
						end else begin
							// The address is sent again without a fresh start condition.
							retry_n = retry_q + 3'd1;
							if (retry_q + 3'd1 >= limit) begin
								state_n = ST_STOP_LOW;
							end else begin
								shift_n   = held_q[0];
								bit_cnt_n = 4'd0;
								state_n   = ST_TX_LOW;
							end
						end
					end else if (!ack_bit) begin
						state_n = ST_STOP_LOW;
					end else if (held_cmd_q == CMD_WR2 && byte_idx_q == 2'd1) begin
						byte_idx_n = 2'd2;
						shift_n    = held_q[2];
						bit_cnt_n  = 4'd0;
						state_n    = ST_TX_LOW;
					end else begin
						status_n = ERR_NONE;
						state_n  = ST_STOP_LOW;
					end
				end
				ST_RX_LOW: state_n = ST_RX_HIGH;
				ST_RX_HIGH: begin
					shift_n   = {shift_q[6:0], q_item.data_level};
					bit_cnt_n = bit_cnt_q + 4'd1;
					state_n   = (bit_cnt_q + 4'd1 >= BITS_PER_BYTE) ? ST_NACK_LOW : ST_RX_LOW;
				end
				ST_NACK_LOW: state_n = ST_NACK_HIGH;
				ST_NACK_HIGH: begin
					read_n  = shift_q;
					state_n = ST_STOP_LOW;
				end
				ST_STOP_LOW: state_n = ST_STOP_HIGH;
				ST_STOP_HIGH: state_n = ST_STOP_END;
				default: begin
					done_n  = 1'b1;
					state_n = ST_IDLE;
				end
			endcase
		end

		case (state_n)
			ST_START: begin
				scl_n = 1'b1;
				sda_n = 1'b0;
			end
			ST_TX_LOW: begin
				scl_n = 1'b0;
				sda_n = shift_n[7];
			end
			ST_TX_HIGH: begin
				scl_n = 1'b1;
				sda_n = shift_n[7];
			end
			ST_ACK_LOW, ST_RX_LOW, ST_NACK_LOW: begin
				scl_n = 1'b0;
				sda_n = 1'b1;
			end
			ST_STOP_LOW: begin
				scl_n = 1'b0;
				sda_n = 1'b0;
			end
			ST_STOP_HIGH: begin
				scl_n = 1'b1;
				sda_n = 1'b0;
			end
			default: begin
				scl_n = 1'b1;
				sda_n = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (step && held_load) begin
			held_q[0] <= q_item.addr_byte;
			held_q[1] <= q_item.first_byte;
			held_q[2] <= q_item.second_byte;
		end
		if (step) begin
			clock_release <= scl_n;
			data_release  <= sda_n;
			busy_res      <= (state_n != ST_IDLE);
			done_res      <= done_n;
			acknowledged  <= ack_n;
			error_code    <= status_n;
			read_byte     <= read_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_cnt_q <= 16'd0;
			bit_cnt_q   <= 4'd0;
			shift_q     <= 8'd0;
			retry_q     <= 3'd0;
			byte_idx_q  <= 2'd0;
			held_cmd_q  <= CMD_NONE;
			status_q    <= ERR_NONE;
			ack_q       <= 1'b0;
			read_q      <= 8'd0;
			out_valid   <= 1'b0;
		end else begin
			if (step) begin
				state_q     <= state_n;
				phase_cnt_q <= phase_cnt_n;
				bit_cnt_q   <= bit_cnt_n;
				shift_q     <= shift_n;
				retry_q     <= retry_n;
				byte_idx_q  <= byte_idx_n;
				held_cmd_q  <= held_cmd_n;
				status_q    <= status_n;
				ack_q       <= ack_n;
				read_q      <= read_n;
				out_valid   <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* tb/i2c_master_checker.sv */
// Checker for the I2C master byte transfer unit: predicts every result item from the accepted ticks.
`timescale 1ns / 100ps

module i2c_master_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  device_address,
	input  logic [7:0]  first_byte,
	input  logic [7:0]  second_byte,
	input  logic        clock_level,
	input  logic        data_level,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        clock_release,
	input  logic        data_release,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic        acknowledged,
	input  logic [1:0]  error_code,
	input  logic [7:0]  read_byte,
	output int          fault_count,
	output int          awaited,
	output logic        engine_busy
);

	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_START,
		PH_TX_LOW,
		PH_TX_HIGH,
		PH_ACK_LOW,
		PH_ACK_HIGH,
		PH_RX_LOW,
		PH_RX_HIGH,
		PH_NACK_LOW,
		PH_NACK_HIGH,
		PH_STOP_LOW,
		PH_STOP_HIGH,
		PH_STOP_END
	} bus_phase_t;

	typedef struct packed {
		logic       clock_release;
		logic       data_release;
		logic       busy;
		logic       done;
		logic       ack;
		logic [1:0] error;
		logic [7:0] rdata;
	} bus_levels_t;

	bus_levels_t awaited_levels[$];
	int          result_index;

	logic [15:0] ticks_cfg;
	logic [2:0]  retry_cfg;
	bus_phase_t  phase;
	logic [15:0] phase_count;
	logic [3:0]  bit_count;
	logic [7:0]  shifter;
	logic [2:0]  retries;
	logic [1:0]  byte_sel;
	logic [7:0]  held [3];
	logic [1:0]  held_cmd;
	logic [1:0]  status;
	logic        ack_seen;
	logic [7:0]  read_value;

	task automatic report_fault(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fault_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			report_fault($sformatf("result %0d %s is %0d, expected %0d",
				result_index, name, got, want));
		end
	endtask

	task automatic reset_engine();
		ticks_cfg = PHASE_TICKS_RESET;
		retry_cfg = RETRY_LIMIT_RESET;
		phase = PH_IDLE;
		phase_count = '0;
		bit_count = '0;
		shifter = '0;
		retries = '0;
		byte_sel = '0;
		held[0] = '0;
		held[1] = '0;
		held[2] = '0;
		held_cmd = CMD_NONE;
		status = ERR_NONE;
		ack_seen = 1'b0;
		read_value = '0;
	endtask

	function automatic logic clock_phase(input bus_phase_t p);
		return p == PH_TX_HIGH || p == PH_ACK_HIGH || p == PH_RX_HIGH ||
			p == PH_NACK_HIGH || p == PH_STOP_HIGH;
	endfunction

	task automatic enter_phase(input bus_phase_t p);
		phase = p;
		phase_count = '0;
	endtask

	task automatic start_byte(input logic [7:0] value);
		shifter = value;
		bit_count = '0;
		enter_phase(PH_TX_LOW);
	endtask

	// Decides what follows the acknowledge slot of a byte.
	task automatic finish_ack(input logic sda_in);
		logic       acked;
		logic [2:0] limit;
		acked = !sda_in;
		limit = (retry_cfg == 3'd0) ? 3'd1 : retry_cfg;
		ack_seen = acked;
		if (byte_sel == 2'd0) begin
			if (acked) begin
				if (held_cmd == CMD_READ) begin
					status = ERR_NONE;
					shifter = '0;
					bit_count = '0;
					enter_phase(PH_RX_LOW);
				end else begin
					status = ERR_DATA;
					byte_sel = 2'd1;
					start_byte(held[1]);
				end
			end else begin
				// The address goes out again without a new start condition.
				retries = retries + 3'd1;
				if (retries >= limit)
					enter_phase(PH_STOP_LOW);
				else
					start_byte(held[0]);
			end
		end else if (!acked) begin
			enter_phase(PH_STOP_LOW);
		end else if (held_cmd == CMD_WR2 && byte_sel == 2'd1) begin
			byte_sel = 2'd2;
			start_byte(held[2]);
		end else begin
			status = ERR_NONE;
			enter_phase(PH_STOP_LOW);
		end
	endtask

	task automatic advance_bus_engine(input logic [1:0] cmd, input logic [7:0] addr,
		input logic [7:0] b1, input logic [7:0] b2, input logic scl_in, input logic sda_in,
		output bus_levels_t levels);
		logic [16:0] span;
		logic        finished;
		span = (ticks_cfg == 16'd0) ? 17'd1 : {1'b0, ticks_cfg};
		finished = 1'b0;
		if (phase == PH_IDLE) begin
			if (cmd != CMD_NONE) begin
				held_cmd = cmd;
				held[0] = (cmd == CMD_READ) ? addr + 8'd1 : addr;
				held[1] = b1;
				held[2] = b2;
				status = ERR_ADDR;
				ack_seen = 1'b0;
				read_value = '0;
				retries = '0;
				byte_sel = '0;
				bit_count = '0;
				enter_phase(PH_START);
			end
		end else if ({1'b0, phase_count} + 17'd1 < span) begin
			phase_count = phase_count + 16'd1;
		end else if (clock_phase(phase) && !scl_in) begin
			// The slave is stretching the clock, so the phase is held.
		end else begin
			case (phase)
				PH_START: start_byte(held[0]);
				PH_TX_LOW: enter_phase(PH_TX_HIGH);
				PH_TX_HIGH: begin
					shifter = shifter << 1;
					bit_count = bit_count + 4'd1;
					if (bit_count >= BITS_PER_BYTE)
						enter_phase(PH_ACK_LOW);
					else
						enter_phase(PH_TX_LOW);
				end
				PH_ACK_LOW: enter_phase(PH_ACK_HIGH);
				PH_ACK_HIGH: finish_ack(sda_in);
				PH_RX_LOW: enter_phase(PH_RX_HIGH);
				PH_RX_HIGH: begin
					shifter = {shifter[6:0], sda_in};
					bit_count = bit_count + 4'd1;
					if (bit_count >= BITS_PER_BYTE)
						enter_phase(PH_NACK_LOW);
					else
						enter_phase(PH_RX_LOW);
				end
				PH_NACK_LOW: enter_phase(PH_NACK_HIGH);
				PH_NACK_HIGH: begin
					read_value = shifter;
					enter_phase(PH_STOP_LOW);
				end
				PH_STOP_LOW: enter_phase(PH_STOP_HIGH);
				PH_STOP_HIGH: enter_phase(PH_STOP_END);
				default: begin
					finished = 1'b1;
					enter_phase(PH_IDLE);
				end
			endcase
		end

		levels.clock_release = 1'b1;
		levels.data_release = 1'b1;
		case (phase)
			PH_START: levels.data_release = 1'b0;
			PH_TX_LOW: begin
				levels.clock_release = 1'b0;
				levels.data_release = shifter[7];
			end
			PH_TX_HIGH: levels.data_release = shifter[7];
			PH_ACK_LOW, PH_RX_LOW, PH_NACK_LOW: levels.clock_release = 1'b0;
			PH_STOP_LOW: begin
				levels.clock_release = 1'b0;
				levels.data_release = 1'b0;
			end
			PH_STOP_HIGH: levels.data_release = 1'b0;
			default: ;
		endcase
		levels.busy = (phase != PH_IDLE);
		levels.done = finished;
		levels.ack = ack_seen;
		levels.error = status;
		levels.rdata = read_value;
	endtask

	always @(posedge clk) begin : watch
		bus_levels_t got;
		bus_levels_t want;
		bus_levels_t fresh;
		if (!arst_n) begin
			reset_engine();
			awaited_levels.delete();
			result_index = 0;
			fault_count = 0;
			awaited <= 0;
			engine_busy <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				if (cfg_index == CFG_PHASE_TICKS)
					ticks_cfg = cfg_data;
				else
					retry_cfg = cfg_data[2:0];
			end
			// Results leave before the new item enters, as they belong to older items.
			if (out_valid && out_ready) begin
				got = {clock_release, data_release, busy_res, done_res, acknowledged,
					error_code, read_byte};
				if (awaited_levels.size() == 0) begin
					report_fault($sformatf("result %0d arrived with no item waiting",
						result_index));
				end else begin
					want = awaited_levels.pop_front();
					compare_field("clock_release", int'(got.clock_release),
						int'(want.clock_release));
					compare_field("data_release", int'(got.data_release),
						int'(want.data_release));
					compare_field("busy_res", int'(got.busy), int'(want.busy));
					compare_field("done_res", int'(got.done), int'(want.done));
					compare_field("acknowledged", int'(got.ack), int'(want.ack));
					compare_field("error_code", int'(got.error), int'(want.error));
					compare_field("read_byte", int'(got.rdata), int'(want.rdata));
				end
				result_index++;
			end
			if (in_valid && in_ready) begin
				advance_bus_engine(command, device_address, first_byte, second_byte,
					clock_level, data_level, fresh);
				awaited_levels.push_back(fresh);
			end
			awaited <= awaited_levels.size();
			engine_busy <= (phase != PH_IDLE);
		end
	end

endmodule

/* tb/tb_i2c_master_byte_transfer_unit.sv */
// Testbench top for the I2C master byte transfer unit: clock, reset, bus ticks and verdict.
`timescale 1ns / 100ps

module tb_i2c_master_byte_transfer_unit;

	import i2cm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write_enable;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  device_address;
	logic [7:0]  first_byte;
	logic [7:0]  second_byte;
	logic        clock_level;
	logic        data_level;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        clock_release;
	logic        data_release;
	logic        busy_res;
	logic        done_res;
	logic        acknowledged;
	logic [1:0]  error_code;
	logic [7:0]  read_byte;

	int   fault_count;
	int   awaited;
	logic engine_busy;

	int burst_left;
	bit steady;

	int       stall_mode;
	int       stall_left;
	int       stall_rot;
	bit [7:0] stall_mask;

	i2c_master_byte_transfer_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.device_address   (device_address),
		.first_byte       (first_byte),
		.second_byte      (second_byte),
		.clock_level      (clock_level),
		.data_level       (data_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.clock_release    (clock_release),
		.data_release     (data_release),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.acknowledged     (acknowledged),
		.error_code       (error_code),
		.read_byte        (read_byte)
	);

	i2c_master_checker bus_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.device_address   (device_address),
		.first_byte       (first_byte),
		.second_byte      (second_byte),
		.clock_level      (clock_level),
		.data_level       (data_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.clock_release    (clock_release),
		.data_release     (data_release),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.acknowledged     (acknowledged),
		.error_code       (error_code),
		.read_byte        (read_byte),
		.fault_count      (fault_count),
		.awaited          (awaited),
		.engine_busy      (engine_busy)
	);

	always #5 clk = ~clk;

	// The receiver picks a new random stall pattern whenever the current one runs out.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 200);
			stall_mask = 8'($urandom_range(0, 255));
		end
		stall_left--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: begin
				out_ready <= stall_mask[stall_rot % 8];
				stall_rot++;
			end
			default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Presents one tick and returns at the edge that accepts it.
	task automatic send_tick(input logic [1:0] cmd, input logic [7:0] addr,
		input logic [7:0] b1, input logic [7:0] b2, input logic scl, input logic sda);
		int   gap;
		logic taken;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		device_address <= addr;
		first_byte <= b1;
		second_byte <= b2;
		clock_level <= scl;
		data_level <= sda;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
	endtask

	// The busy flag lags by one item, so one idle tick always goes out first.
	task automatic drain_engine();
		do begin
			send_tick(CMD_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
		end while (engine_busy);
	endtask

	task automatic load_settings(input logic [15:0] ticks, input logic [2:0] retry);
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write_enable <= 1'b1;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= {13'd0, retry};
		@(posedge clk);
		cfg_write_enable <= 1'b0;
	endtask

	task automatic random_ticks(input int count);
		int   k;
		int   ack_bias;
		int   stretch_left;
		logic scl;
		logic sda;
		case ($urandom_range(0, 2))
			0: ack_bias = 50;
			1: ack_bias = 85;
			default: ack_bias = 97;
		endcase
		stretch_left = 0;
		for (k = 0; k < count; k++) begin
			if (stretch_left == 0 && $urandom_range(0, 99) < 3)
				stretch_left = $urandom_range(1, 12);
			scl = (stretch_left == 0);
			if (stretch_left > 0)
				stretch_left--;
			sda = ($urandom_range(0, 99) >= ack_bias);
			send_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), scl, sda);
		end
	endtask

	initial begin
		#50_000_000;
		$display("tb_i2c_master_byte_transfer_unit failed");
		$finish;
	end

	initial begin : stimulus
		int i;
		int p;
		arst_n <= 1'b0;
		cfg_write_enable <= 1'b0;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_NONE;
		device_address <= '0;
		first_byte <= '0;
		second_byte <= '0;
		clock_level <= 1'b1;
		data_level <= 1'b1;
		steady = 1'b0;
		burst_left = 0;
		stall_left = 0;
		stall_rot = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero ticks and a zero retry limit both behave as one.
		load_settings(16'd0, 3'd0);
		send_tick(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
		send_tick(CMD_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		send_tick(CMD_WR1, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1);
		// No acknowledge ever comes, so the address times out after one send.
		// Commands while busy are ignored, and SCL is held low for a few ticks.
		for (i = 0; i < 26; i++) begin
			if (i == 2)
				send_tick(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
			else if (i == 3)
				send_tick(CMD_WR2, 8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b1);
			else
				send_tick(CMD_NONE, 8'h00, 8'h00, 8'h00, !(i >= 5 && i <= 7), 1'b1);
		end

		for (p = 0; p < 6; p++) begin
			drain_engine();
			case (p)
				0: load_settings(16'd1, 3'd7);
				1: load_settings(16'd1, 3'd1);
				default: load_settings(16'($urandom_range(1, 3)), 3'($urandom_range(1, 7)));
			endcase
			steady = (p == 2);
			random_ticks(60);
		end

		// A long phase setting: the start phase is still running when the ticks stop.
		drain_engine();
		load_settings(16'hFFFF, 3'd2);
		steady = 1'b0;
		send_tick(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b1, 1'b0);
		for (i = 0; i < 30; i++) begin
			send_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1,
				1'($urandom_range(0, 1)));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("tb_i2c_master_byte_transfer_unit passed");
		else
			$display("tb_i2c_master_byte_transfer_unit failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_back.sv
hw/rtl/i2c_master_byte_transfer_unit.sv
tb/i2c_master_checker.sv
tb/tb_i2c_master_byte_transfer_unit.sv
